/* src/trapezoid_profile_follower_unit_defines.svh */
// ----------------------------------------------------------------------------
// Trapezoid profile follower assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_PROFILE_FOLLOWER_UNIT_DEFINES_SVH
`define TRAPEZOID_PROFILE_FOLLOWER_UNIT_DEFINES_SVH

// same-cycle implication
`define TPF_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define TPF_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

/* src/tpf_pkg.sv */
// ----------------------------------------------------------------------------
// Trapezoid profile follower package
// Constants, controller states, datapath operations and shared helpers.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int          TIMESTEP_MS = 10;
    localparam logic [16:0] TICK_TOP    = 17'h1FFFF;
    localparam logic [63:0] DRIVE_LIMIT = 64'd8323072;

    // x * TIMESTEP_MS / 1000 is x / 100; reciprocal exact for x below 2^31
    localparam logic [23:0] CENTI       = 24'd100;
    localparam logic [31:0] RECIP_CENTI = 32'd2748779070;

    typedef enum logic [2:0] {
        CFG_RAMP   = 3'd0,
        CFG_CRUISE = 3'd1,
        CFG_ACCEL  = 3'd2,
        CFG_PEAK   = 3'd3,
        CFG_KP     = 3'd4,
        CFG_KD     = 3'd5,
        CFG_KV     = 3'd6,
        CFG_KA     = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EVAL, ST_VWAIT, ST_POS, ST_PWAIT, ST_ERR, ST_RATE, ST_RWAIT,
        ST_MUL, ST_ACC, ST_LR, ST_CHK, ST_SHIFT, ST_DLW, ST_DR, ST_DRW, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_EVAL, OP_VEL_FIN, OP_POS_START, OP_POS_FIN, OP_ERR,
        OP_RATE_START, OP_RATE_FIN, OP_MUL, OP_ACC, OP_LR, OP_SHIFT, OP_DL_START,
        OP_DL_FIN, OP_DR_START, OP_DR_FIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] term;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic prof_done;
        logic seg_cruise;
        logic over_limit;
        logic wide_mag;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

/* src/tpf_div.sv */
// ----------------------------------------------------------------------------
// Trapezoid profile follower dividers
// Unsigned 64 by 64 bit restoring divider, one quotient bit per cycle, and a
// reciprocal divide-by-100 unit for 48 bit dividends.
// ----------------------------------------------------------------------------
module tpf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic [64:0] w_shift;
    logic        w_fit;

    assign w_shift = {r_rem, r_quo[63]};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? 64'(w_shift - {1'b0, r_dvs}) : w_shift[63:0];
            r_quo <= {r_quo[62:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// upper 24 bits, then remainder joined with the lower 24 bits
module tpf_div100 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    output logic        o_done,
    output logic [47:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_phase;
    logic [47:0] r_x;
    logic [23:0] r_qh;
    logic [23:0] r_ql;
    logic [30:0] r_y;
    logic [30:0] w_mop;
    logic [62:0] w_prod;
    logic [23:0] w_rh;

    assign w_mop  = (r_phase == 2'd0) ? 31'(r_x[47:24]) : r_y;
    assign w_prod = 63'(w_mop) * 63'(tpf_pkg::RECIP_CENTI);
    assign w_rh   = r_x[47:24] - 24'(r_qh * tpf_pkg::CENTI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end else if (r_busy) begin
            case (r_phase)
                2'd0:    r_qh <= w_prod[61:38];
                2'd1:    r_y  <= {w_rh[6:0], r_x[23:0]};
                default: r_ql <= w_prod[61:38];
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = {r_qh, r_ql};

endmodule

/* src/tpf_datapath.sv */
// ----------------------------------------------------------------------------
// Trapezoid profile follower datapath
// Registers, profile state, shared multiplier and divider, output stage.
// ----------------------------------------------------------------------------
module tpf_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_addr,
    input  logic [30:0]          i_cfg_wdata,
    input  tpf_pkg::t_cmd        i_cmd,
    output tpf_pkg::t_stat       o_stat,
    input  logic                 i_start_req,
    input  logic signed [31:0]   i_meas,
    input  logic [9:0]           i_ems,
    input  logic signed [31:0]   i_ang,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [143:0]         o_m_tdata,
    output logic                 o_m_tuser
);

    logic [15:0] r_ramp, r_cruise;
    logic [30:0] r_accel, r_peak, r_kp, r_kd, r_kv, r_ka;

    logic [16:0]        r_tick;
    logic signed [31:0] r_pos, r_prev, r_start;
    logic               r_first;

    logic signed [31:0] r_meas, r_ang;
    logic [9:0]         r_ems;
    logic signed [31:0] r_vel, r_acc, r_err, r_rate;
    logic               r_seg_acc, r_neg, r_fin;
    logic signed [63:0] r_prod, r_ctl, r_left, r_right;
    logic [63:0]        r_ml, r_mr, r_m;
    logic [23:0]        r_lres, r_rres;
    logic               r_csel;

    logic               r_ov;
    logic [143:0]       r_odata;
    logic               r_ouser;

    logic [16:0]        w_cruise_end;
    logic [17:0]        w_total;
    logic               w_prof_done, w_seg_acc, w_seg_cruise, w_out_free;
    logic [16:0]        w_span;
    logic               w_div_start, w_div_done, w_sdiv_done;
    logic [63:0]        w_div_a, w_div_b, w_q, w_sq;
    logic               w_cdiv_start, w_cdiv_done;
    logic [47:0]        w_cdiv_a, w_cq;
    logic signed [63:0] w_qs, w_vel64, w_num, w_diff, w_cur, w_lft, w_rgt;
    logic signed [31:0] w_cur32, w_mx;
    logic [30:0]        w_gain;
    logic [63:0]        w_lmag, w_rmag;
    logic [9:0]         w_dt;

    assign w_cruise_end = 17'(r_ramp) + 17'(r_cruise);
    assign w_total      = 18'(w_cruise_end) + 18'(r_ramp);
    assign w_prof_done  = (18'(r_tick) >= w_total) || (r_tick == tpf_pkg::TICK_TOP);
    assign w_seg_acc    = (r_tick < 17'(r_ramp));
    assign w_seg_cruise = !w_seg_acc && (r_tick < w_cruise_end);
    assign w_span       = w_seg_acc ? r_tick : 17'(r_tick - w_cruise_end);
    assign w_out_free   = !r_ov || i_m_tready;

    assign w_div_done = w_sdiv_done || w_cdiv_done;
    assign w_q        = r_csel ? 64'(w_cq) : w_sq;

    assign w_qs    = r_neg ? -$signed(w_q) : $signed(w_q);
    assign w_vel64 = 64'(r_vel);
    assign w_diff  = 64'(r_err) - 64'(r_prev);
    assign w_num   = w_diff * 64'sd1000;
    assign w_cur   = 64'(r_meas) - 64'(r_start);
    assign w_cur32 = tpf_pkg::sat32(w_cur);
    assign w_dt    = r_first ? 10'(tpf_pkg::TIMESTEP_MS) : ((r_ems == 10'd0) ? 10'd1 : r_ems);
    assign w_lft   = r_ctl + 64'(r_ang);
    assign w_rgt   = r_ctl - 64'(r_ang);
    assign w_lmag  = w_lft[63] ? 64'(-w_lft) : 64'(w_lft);
    assign w_rmag  = w_rgt[63] ? 64'(-w_rgt) : 64'(w_rgt);

    always_comb begin
        case (i_cmd.term)
            2'd0:    begin w_gain = r_kv; w_mx = r_vel;  end
            2'd1:    begin w_gain = r_ka; w_mx = r_acc;  end
            2'd2:    begin w_gain = r_kp; w_mx = r_err;  end
            default: begin w_gain = r_kd; w_mx = r_rate; end
        endcase
    end

    always_comb begin
        w_div_start  = 1'b0;
        w_div_a      = '0;
        w_div_b      = '0;
        w_cdiv_start = 1'b0;
        w_cdiv_a     = '0;
        unique case (i_cmd.op)
            tpf_pkg::OP_EVAL: begin
                w_cdiv_start = !w_prof_done && !w_seg_cruise;
                w_cdiv_a     = 48'(r_accel) * 48'(w_span);
            end
            tpf_pkg::OP_POS_START: begin
                w_cdiv_start = 1'b1;
                w_cdiv_a     = r_vel[31] ? 48'(-w_vel64) : 48'(w_vel64);
            end
            tpf_pkg::OP_RATE_START: begin
                w_div_start = 1'b1;
                w_div_a     = w_num[63] ? 64'(-w_num) : 64'(w_num);
                w_div_b     = 64'(w_dt);
            end
            tpf_pkg::OP_DL_START: begin
                w_div_start = 1'b1;
                w_div_a     = r_ml * tpf_pkg::DRIVE_LIMIT;
                w_div_b     = r_m;
            end
            tpf_pkg::OP_DR_START: begin
                w_div_start = 1'b1;
                w_div_a     = r_mr * tpf_pkg::DRIVE_LIMIT;
                w_div_b     = r_m;
            end
            default: ;
        endcase
    end

    tpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_sdiv_done),
        .o_quotient (w_sq)
    );

    tpf_div100 u_div100 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cdiv_start),
        .i_dividend (w_cdiv_a),
        .o_done     (w_cdiv_done),
        .o_quotient (w_cq)
    );

    always_ff @(posedge i_clk) begin
        if (w_cdiv_start) begin
            r_csel <= 1'b1;
        end else if (w_div_start) begin
            r_csel <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp   <= '0;
            r_cruise <= '0;
            r_accel  <= '0;
            r_peak   <= '0;
            r_kp     <= '0;
            r_kd     <= '0;
            r_kv     <= '0;
            r_ka     <= '0;
        end else if (i_cfg_we) begin
            unique case (tpf_pkg::t_cfg_idx'(i_cfg_addr))
                tpf_pkg::CFG_RAMP:   r_ramp   <= i_cfg_wdata[15:0];
                tpf_pkg::CFG_CRUISE: r_cruise <= i_cfg_wdata[15:0];
                tpf_pkg::CFG_ACCEL:  r_accel  <= i_cfg_wdata;
                tpf_pkg::CFG_PEAK:   r_peak   <= i_cfg_wdata;
                tpf_pkg::CFG_KP:     r_kp     <= i_cfg_wdata;
                tpf_pkg::CFG_KD:     r_kd     <= i_cfg_wdata;
                tpf_pkg::CFG_KV:     r_kv     <= i_cfg_wdata;
                default:             r_ka     <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_pos   <= '0;
            r_prev  <= '0;
            r_start <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.op == tpf_pkg::OP_LOAD) begin
            if (i_start_req) begin
                r_tick  <= '0;
                r_pos   <= '0;
                r_prev  <= '0;
                r_start <= i_meas;
                r_first <= 1'b1;
            end
        end else if (i_cmd.op == tpf_pkg::OP_POS_FIN) begin
            r_pos <= tpf_pkg::sat32(64'(r_pos) + w_qs);
        end else if (i_cmd.op == tpf_pkg::OP_LR) begin
            r_prev  <= r_err;
            r_first <= 1'b0;
            if (r_tick != tpf_pkg::TICK_TOP) begin
                r_tick <= r_tick + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tpf_pkg::OP_LOAD: begin
                r_meas <= i_meas;
                r_ems  <= i_ems;
                r_ang  <= i_ang;
            end
            tpf_pkg::OP_EVAL: begin
                r_seg_acc <= w_seg_acc;
                r_fin     <= w_prof_done;
                if (w_prof_done) begin
                    r_vel  <= '0;
                    r_acc  <= '0;
                    r_lres <= '0;
                    r_rres <= '0;
                end else if (w_seg_cruise) begin
                    r_vel <= 32'(r_peak);
                    r_acc <= '0;
                end
            end
            tpf_pkg::OP_VEL_FIN: begin
                r_neg <= 1'b0;
                if (r_seg_acc) begin
                    r_vel <= tpf_pkg::sat32($signed(w_q));
                    r_acc <= 32'(r_accel);
                end else begin
                    r_vel <= tpf_pkg::sat32(64'(r_peak) - $signed(w_q));
                    r_acc <= -32'(r_accel);
                end
            end
            tpf_pkg::OP_POS_START:  r_neg <= r_vel[31];
            tpf_pkg::OP_ERR: begin
                r_err <= tpf_pkg::sat32(64'(r_pos) - 64'(w_cur32));
                r_ctl <= '0;
            end
            tpf_pkg::OP_RATE_START: r_neg <= w_num[63];
            tpf_pkg::OP_RATE_FIN:   r_rate <= tpf_pkg::sat32(w_qs - w_vel64);
            tpf_pkg::OP_MUL:        r_prod <= $signed({1'b0, w_gain}) * w_mx;
            tpf_pkg::OP_ACC:        r_ctl <= r_ctl + (r_prod >>> 16);
            tpf_pkg::OP_LR: begin
                r_left  <= w_lft;
                r_right <= w_rgt;
                r_ml    <= w_lmag;
                r_mr    <= w_rmag;
                r_m     <= (w_lmag > w_rmag) ? w_lmag : w_rmag;
                r_lres  <= w_lft[23:0];
                r_rres  <= w_rgt[23:0];
            end
            tpf_pkg::OP_SHIFT: begin
                r_ml <= r_ml >> 1;
                r_mr <= r_mr >> 1;
                r_m  <= r_m >> 1;
            end
            tpf_pkg::OP_DL_FIN: r_lres <= r_left[63] ? 24'(-w_q) : w_q[23:0];
            tpf_pkg::OP_DR_FIN: r_rres <= r_right[63] ? 24'(-w_q) : w_q[23:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == tpf_pkg::OP_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tpf_pkg::OP_OUT && w_out_free) begin
            r_odata <= {r_acc, r_vel, r_pos, r_rres, r_lres};
            r_ouser <= r_fin;
        end
    end

    assign o_stat.div_done   = w_div_done;
    assign o_stat.prof_done  = w_prof_done;
    assign o_stat.seg_cruise = w_seg_cruise;
    assign o_stat.over_limit = (r_m > tpf_pkg::DRIVE_LIMIT);
    assign o_stat.wide_mag   = (r_m[63:40] != 24'd0);
    assign o_stat.out_free   = w_out_free;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

/* src/tpf_ctrl.sv */
// ----------------------------------------------------------------------------
// Trapezoid profile follower controller
// Sequences one tick through the datapath operations.
// ----------------------------------------------------------------------------
module tpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tpf_pkg::t_stat i_stat,
    output tpf_pkg::t_cmd  o_cmd
);

    tpf_pkg::t_state r_state, n_state;
    logic [1:0]      r_term, n_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpf_pkg::ST_IDLE;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_term     = r_term;
        o_cmd.op   = tpf_pkg::OP_NONE;
        o_cmd.term = r_term;
        o_s_tready = 1'b0;
        unique case (r_state)
            tpf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = tpf_pkg::OP_LOAD;
                    n_state  = tpf_pkg::ST_EVAL;
                end
            end
            tpf_pkg::ST_EVAL: begin
                o_cmd.op = tpf_pkg::OP_EVAL;
                if (i_stat.prof_done) begin
                    n_state = tpf_pkg::ST_OUT;
                end else if (i_stat.seg_cruise) begin
                    n_state = tpf_pkg::ST_POS;
                end else begin
                    n_state = tpf_pkg::ST_VWAIT;
                end
            end
            tpf_pkg::ST_VWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = tpf_pkg::OP_VEL_FIN;
                    n_state  = tpf_pkg::ST_POS;
                end
            end
            tpf_pkg::ST_POS: begin
                o_cmd.op = tpf_pkg::OP_POS_START;
                n_state  = tpf_pkg::ST_PWAIT;
            end
            tpf_pkg::ST_PWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = tpf_pkg::OP_POS_FIN;
                    n_state  = tpf_pkg::ST_ERR;
                end
            end
            tpf_pkg::ST_ERR: begin
                o_cmd.op = tpf_pkg::OP_ERR;
                n_state  = tpf_pkg::ST_RATE;
            end
            tpf_pkg::ST_RATE: begin
                o_cmd.op = tpf_pkg::OP_RATE_START;
                n_state  = tpf_pkg::ST_RWAIT;
            end
            tpf_pkg::ST_RWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = tpf_pkg::OP_RATE_FIN;
                    n_term   = '0;
                    n_state  = tpf_pkg::ST_MUL;
                end
            end
            tpf_pkg::ST_MUL: begin
                o_cmd.op = tpf_pkg::OP_MUL;
                n_state  = tpf_pkg::ST_ACC;
            end
            tpf_pkg::ST_ACC: begin
                o_cmd.op = tpf_pkg::OP_ACC;
                n_term   = r_term + 2'd1;
                n_state  = (r_term == 2'd3) ? tpf_pkg::ST_LR : tpf_pkg::ST_MUL;
            end
            tpf_pkg::ST_LR: begin
                o_cmd.op = tpf_pkg::OP_LR;
                n_state  = tpf_pkg::ST_CHK;
            end
            tpf_pkg::ST_CHK: begin
                n_state = i_stat.over_limit ? tpf_pkg::ST_SHIFT : tpf_pkg::ST_OUT;
            end
            tpf_pkg::ST_SHIFT: begin
                if (i_stat.wide_mag) begin
                    o_cmd.op = tpf_pkg::OP_SHIFT;
                end else begin
                    o_cmd.op = tpf_pkg::OP_DL_START;
                    n_state  = tpf_pkg::ST_DLW;
                end
            end
            tpf_pkg::ST_DLW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = tpf_pkg::OP_DL_FIN;
                    n_state  = tpf_pkg::ST_DR;
                end
            end
            tpf_pkg::ST_DR: begin
                o_cmd.op = tpf_pkg::OP_DR_START;
                n_state  = tpf_pkg::ST_DRW;
            end
            tpf_pkg::ST_DRW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = tpf_pkg::OP_DR_FIN;
                    n_state  = tpf_pkg::ST_OUT;
                end
            end
            tpf_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = tpf_pkg::OP_OUT;
                    n_state  = tpf_pkg::ST_IDLE;
                end
            end
            default: n_state = tpf_pkg::ST_IDLE;
        endcase
    end

endmodule

/* src/trapezoid_profile_follower_unit.sv */
// ----------------------------------------------------------------------------
// Trapezoid profile follower unit
// Trapezoidal setpoint with feedforward plus PD and scaled left/right drive.
//
//   channel  dir  signals                    word
//   s        in   i_s_tvalid/o_s_tready      one control tick
//   m        out  o_m_tvalid/i_m_tready      one drive command
//   cfg      in   i_cfg_we/addr/wdata        one register write
//
// A tick past the end of the profile goes from evaluation straight to output.
// On an active tick, divisions by the step rate run on the reciprocal unit,
// the error-rate and drive-scaling divisions share one radix-2 divider (one
// to three per tick), plus one shift per cycle while the drive magnitude is
// 2^40 or more. Synchronous active-low reset, no clear pass. A stalled
// result holds in the output register; the next word is taken while it
// waits.
// ----------------------------------------------------------------------------
`include "trapezoid_profile_follower_unit_defines.svh"

module trapezoid_profile_follower_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // measured_distance[31:0], elapsed_ms[41:32], angular_correction[73:42]
    input  logic [79:0]  i_s_tdata,
    // start_req
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_drive[23:0], right_drive[47:24], setpoint_position[79:48],
    // setpoint_velocity[111:80], setpoint_accel[143:112]
    output logic [143:0] o_m_tdata,
    // finished
    output logic         o_m_tuser
);

    tpf_pkg::t_cmd  w_cmd;
    tpf_pkg::t_stat w_stat;

    logic signed [23:0] w_ldrv, w_rdrv;
    logic               w_ldrv_ok, w_rdrv_ok, w_fin_zero;

    tpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tpf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_start_req (i_s_tuser),
        .i_meas      (i_s_tdata[31:0]),
        .i_ems       (i_s_tdata[41:32]),
        .i_ang       (i_s_tdata[73:42]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    assign w_ldrv     = $signed(o_m_tdata[23:0]);
    assign w_rdrv     = $signed(o_m_tdata[47:24]);
    assign w_ldrv_ok  = (w_ldrv <= 24'sd8323072) && (w_ldrv >= -24'sd8323072);
    assign w_rdrv_ok  = (w_rdrv <= 24'sd8323072) && (w_rdrv >= -24'sd8323072);
    assign w_fin_zero = (o_m_tdata[47:0] == 48'd0) && (o_m_tdata[143:80] == 64'd0);

    `TPF_ASSERT_IMP(a_fin_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, w_fin_zero, "finished word with nonzero drive")
    `TPF_ASSERT_IMP(a_left_lim, i_clk, i_rst_n, o_m_tvalid, w_ldrv_ok, "left drive over limit")
    `TPF_ASSERT_IMP(a_right_lim, i_clk, i_rst_n, o_m_tvalid, w_rdrv_ok, "right drive over limit")
    `TPF_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while a tick is in work")

endmodule
